>>> rtl/core/smd_pkg.sv
// Shared types, constants and state encodings for the SHA-1 digest engine.
`default_nettype none

package smd_pkg;

   localparam int SMD_FIFO_DEPTH = 4;
   localparam int SMD_FIFO_AW    = $clog2(SMD_FIFO_DEPTH);
   localparam int SMD_LEN_W      = 61;
   localparam int SMD_ROUNDS     = 80;
   localparam int SMD_BLOCK_WORDS = 16;

   localparam logic [31:0] SMD_IV [5] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam logic [31:0] SMD_K0 = 32'h5a827999;
   localparam logic [31:0] SMD_K1 = 32'h6ed9eba1;
   localparam logic [31:0] SMD_K2 = 32'h8f1bbcdc;
   localparam logic [31:0] SMD_K3 = 32'hca62c1d6;

   localparam logic [7:0] SMD_PAD_MARK = 8'h80;

   // one message word on its way to the compression unit
   typedef struct packed {
      logic        eom;
      logic [31:0] word;
   } smd_word_type;

   typedef enum logic [1:0] {
      F_DATA,
      F_MARK,
      F_FILL
   } smd_front_state_type;

   typedef enum logic [1:0] {
      B_ROUND,
      B_ADD,
      B_OUT
   } smd_back_state_type;

endpackage

`default_nettype wire

>>> rtl/core/smd_if.sv
// Byte request and digest response channel interfaces.
`default_nettype none

interface smd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last;

   modport source (output valid, data_byte, byte_valid, last, input ready);
   modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface smd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

>>> rtl/core/smd_fifo.sv
// Short word queue between the byte packer and the compression unit.
`default_nettype none

module smd_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  smd_pkg::smd_word_type push_word,
   output logic                 full,
   input  logic                 pop,
   output smd_pkg::smd_word_type head_word,
   output logic                 head_valid
);
   import smd_pkg::*;

   smd_word_type           mem_ff [SMD_FIFO_DEPTH];
   logic [SMD_FIFO_AW-1:0] wr_ff, wr_in;
   logic [SMD_FIFO_AW-1:0] rd_ff, rd_in;
   logic [SMD_FIFO_AW:0]   cnt_ff, cnt_in;

   always_comb begin
      full       = (cnt_ff == (SMD_FIFO_AW+1)'(SMD_FIFO_DEPTH));
      head_valid = (cnt_ff != '0);
      head_word  = mem_ff[rd_ff];
      wr_in      = push ? wr_ff + SMD_FIFO_AW'(1) : wr_ff;
      rd_in      = pop ? rd_ff + SMD_FIFO_AW'(1) : rd_ff;
      cnt_in     = cnt_ff + (SMD_FIFO_AW+1)'(push) - (SMD_FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/smd_front.sv
// Byte packer: gathers bytes into words, counts length and generates padding.
`default_nettype none

module smd_front (
   input  logic                  clock,
   input  logic                  reset,
   smd_req_if.sink               req_bus,
   output logic                  push,
   output smd_pkg::smd_word_type push_word,
   input  logic                  fifo_full
);
   import smd_pkg::*;

   smd_front_state_type  state_ff, state_in;
   logic [23:0]          acc_ff, acc_in;
   logic [1:0]           bc_ff, bc_in;
   logic [3:0]           wc_ff, wc_in;
   logic [SMD_LEN_W-1:0] len_ff, len_in;
   logic                 wrap_ff, wrap_in;
   logic                 accept;
   logic [63:0]          len_bits;
   logic [31:0]          mark_word;
   logic                 len_lo_turn;

   always_comb begin
      len_bits    = {len_ff, 3'b000};
      mark_word   = {acc_ff, SMD_PAD_MARK} << (5'd24 - {bc_ff, 3'b000});
      len_lo_turn = !wrap_ff && (wc_ff == 4'd15);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_DATA: begin
            if (accept && req_bus.last) begin
               state_in = F_MARK;
            end
         end
         F_MARK: begin
            if (!fifo_full) begin
               state_in = F_FILL;
            end
         end
         F_FILL: begin
            if (!fifo_full && len_lo_turn) begin
               state_in = F_DATA;
            end
         end
         default: state_in = F_DATA;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_bus.ready  = (state_ff == F_DATA) && !fifo_full;
      accept         = req_bus.valid && req_bus.ready;
      push           = 1'b0;
      push_word.eom  = 1'b0;
      push_word.word = {acc_ff, req_bus.data_byte};
      acc_in         = acc_ff;
      bc_in          = bc_ff;
      wc_in          = wc_ff;
      len_in         = len_ff;
      wrap_in        = wrap_ff;
      unique case (state_ff)
         F_DATA: begin
            if (accept && req_bus.byte_valid) begin
               acc_in = {acc_ff[15:0], req_bus.data_byte};
               bc_in  = bc_ff + 2'd1;
               len_in = len_ff + SMD_LEN_W'(1);
               if (bc_ff == 2'd3) begin
                  push  = 1'b1;
                  wc_in = wc_ff + 4'd1;
               end
            end
         end
         F_MARK: begin
            push_word.word = mark_word;
            if (!fifo_full) begin
               push    = 1'b1;
               wc_in   = wc_ff + 4'd1;
               bc_in   = 2'd0;
               // mark in word 14 leaves no room for the length; in word 15 the block is full
               wrap_in = (wc_ff == 4'd14);
            end
         end
         F_FILL: begin
            if (!wrap_ff && wc_ff == 4'd14) begin
               push_word.word = len_bits[63:32];
            end else if (len_lo_turn) begin
               push_word.word = len_bits[31:0];
               push_word.eom  = 1'b1;
            end else begin
               push_word.word = '0;
            end
            if (!fifo_full) begin
               push  = 1'b1;
               wc_in = wc_ff + 4'd1;
               if (wc_ff == 4'd15) begin
                  wrap_in = 1'b0;
               end
               if (len_lo_turn) begin
                  len_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_DATA;
         bc_ff    <= '0;
         wc_ff    <= '0;
         len_ff   <= '0;
         wrap_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         bc_ff    <= bc_in;
         wc_ff    <= wc_in;
         len_ff   <= len_in;
         wrap_ff  <= wrap_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/smd_back.sv
// Compression unit: 80 rounds per block, chaining update and digest output.
`default_nettype none

module smd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  smd_pkg::smd_word_type head_word,
   input  logic                  head_valid,
   output logic                  pop,
   smd_rsp_if.source             rsp_bus
);
   import smd_pkg::*;

   smd_back_state_type state_ff, state_in;
   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] win_ff [SMD_BLOCK_WORDS];
   logic [31:0] win_in [SMD_BLOCK_WORDS];
   logic [6:0]  t_ff, t_in;
   logic        eom_ff, eom_in;
   logic [2:0]  idx_ff, idx_in;
   logic        need_word, step, out_beat;
   logic [31:0] sched, w_t, f_val, k_val, tmp;

   always_comb begin
      need_word = (t_ff < 7'(SMD_BLOCK_WORDS));
      step      = (state_ff == B_ROUND) && (!need_word || head_valid);
      pop       = step && need_word;
      sched     = win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0];
      w_t       = need_word ? head_word.word : {sched[30:0], sched[31]};
      priority if (t_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = SMD_K0;
      end else if (t_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = SMD_K1;
      end else if (t_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = SMD_K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = SMD_K3;
      end
      tmp      = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_t;
      out_beat = rsp_bus.valid && rsp_bus.ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_ROUND: begin
            if (step && t_ff == 7'(SMD_ROUNDS - 1)) begin
               state_in = B_ADD;
            end
         end
         B_ADD:   state_in = eom_ff ? B_OUT : B_ROUND;
         B_OUT: begin
            if (out_beat && idx_ff == 3'd4) begin
               state_in = B_ROUND;
            end
         end
         default: state_in = B_ROUND;
      endcase
   end

   // outputs and datapath
   always_comb begin
      rsp_bus.valid       = (state_ff == B_OUT);
      rsp_bus.digest_word = h_ff[idx_ff];
      rsp_bus.word_index  = idx_ff;
      rsp_bus.last_word   = (idx_ff == 3'd4);
      h_in   = h_ff;
      win_in = win_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      c_in   = c_ff;
      d_in   = d_ff;
      e_in   = e_ff;
      t_in   = t_ff;
      eom_in = eom_ff;
      idx_in = idx_ff;
      unique case (state_ff)
         B_ROUND: begin
            if (step) begin
               for (int i = 0; i < SMD_BLOCK_WORDS - 1; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               win_in[SMD_BLOCK_WORDS-1] = w_t;
               a_in = tmp;
               b_in = a_ff;
               c_in = {b_ff[1:0], b_ff[31:2]};
               d_in = c_ff;
               e_in = d_ff;
               t_in = t_ff + 7'd1;
               if (pop) begin
                  eom_in = head_word.eom;
               end
            end
         end
         B_ADD: begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            h_in[4] = h_ff[4] + e_ff;
            a_in    = h_in[0];
            b_in    = h_in[1];
            c_in    = h_in[2];
            d_in    = h_in[3];
            e_in    = h_in[4];
            t_in    = '0;
         end
         B_OUT: begin
            if (out_beat) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd4) begin
                  idx_in = '0;
                  eom_in = 1'b0;
                  h_in   = SMD_IV;
                  a_in   = SMD_IV[0];
                  b_in   = SMD_IV[1];
                  c_in   = SMD_IV[2];
                  d_in   = SMD_IV[3];
                  e_in   = SMD_IV[4];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_ROUND;
         h_ff     <= SMD_IV;
         a_ff     <= SMD_IV[0];
         b_ff     <= SMD_IV[1];
         c_ff     <= SMD_IV[2];
         d_ff     <= SMD_IV[3];
         e_ff     <= SMD_IV[4];
         t_ff     <= '0;
         eom_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         h_ff     <= h_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         c_ff     <= c_in;
         d_ff     <= d_in;
         e_ff     <= e_in;
         t_ff     <= t_in;
         eom_ff   <= eom_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      t_ff <= 7'(SMD_ROUNDS))
      else $error("round counter out of range");

   a_pop_has_word: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid && t_ff < 7'(SMD_BLOCK_WORDS))
      else $error("word taken from empty queue or outside load rounds");

   a_digest_restart: assert property (@(posedge clock) disable iff (reset)
      out_beat && rsp_bus.last_word |=> h_ff[0] == SMD_IV[0] && t_ff == '0
         && state_ff == B_ROUND)
      else $error("engine did not restart after final digest beat");

   a_out_after_eom: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_OUT && $past(state_ff) == B_ADD |-> $past(eom_ff))
      else $error("digest output without end of message");

endmodule

`default_nettype wire

>>> rtl/core/sha1_message_digest.sv
// Byte-stream digest engine: front packer and pad generator, word queue, round engine.
// Throughput: bytes enter at one per cycle while the packer is taking data and the queue has
//   room; a block takes 80 rounds and a chaining add, waiting for the packer in its 16 load rounds.
// After the last beat: padding words, one or two blocks, then five digest beats at one per
//   cycle while the receiver is ready; a new message may enter during output.
// Synchronous active-high reset loads the initial chaining value and empties the queue.
`default_nettype none

module sha1_message_digest (
   input  logic       clock,
   input  logic       reset,
   smd_req_if.sink    req_bus,
   smd_rsp_if.source  rsp_bus
);
   import smd_pkg::*;

   logic         push, pop, fifo_full, head_valid;
   smd_word_type push_word, head_word;

   smd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .push      (push),
      .push_word (push_word),
      .fifo_full (fifo_full)
   );

   smd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (push_word),
      .full       (fifo_full),
      .pop        (pop),
      .head_word  (head_word),
      .head_valid (head_valid)
   );

   smd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_word  (head_word),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

>>> bench/tb_sha1_message_digest.sv
// Self-checking bench for the SHA-1 byte-stream digest engine, with its own digest predictor.
module tb_sha1_message_digest;
   timeunit 1ns;
   timeprecision 1ps;

   import smd_pkg::*;

   localparam int IDLE_PCT     = 30;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 250;
   localparam int TARGET_BEATS = 300;

   typedef struct {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } byte_beat_type;

   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   logic clock;
   logic reset;

   smd_req_if req_bus();
   smd_rsp_if rsp_bus();

   sha1_message_digest DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   byte_beat_type   byte_queue [$];
   digest_beat_type digest_due [$];

   logic [31:0] chain [5];
   logic [7:0]  block_buf [64];
   int unsigned fill_level;
   logic [60:0] length_bytes;

   int unsigned mismatches;
   int unsigned beats_total;
   int unsigned beats_sent;
   int unsigned words_seen;
   int unsigned messages_queued;
   int unsigned messages_hashed;
   int unsigned bytes_queued;
   int unsigned idle_cycles;
   bit          steady;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic void restart_chain();
      for (int i = 0; i < 5; i++)
         chain[i] = SMD_IV[i];
      fill_level   = 0;
      length_bytes = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
         w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      for (int i = 16; i < 80; i++) begin
         t    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
         w[i] = {t[30:0], t[31]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = SMD_K0;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = SMD_K1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = SMD_K2;
         end else begin
            f = b ^ c ^ d;
            k = SMD_K3;
         end
         t = {a[26:0], a[31:27]} + f + e + k + w[i];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
   endfunction

   // fold one accepted beat into the running hash; a last beat queues the five digest words
   function automatic void absorb_beat(input byte_beat_type bt);
      logic [63:0]     bit_len;
      digest_beat_type dw;
      if (bt.byte_valid) begin
         block_buf[fill_level] = bt.data_byte;
         fill_level++;
         length_bytes++;
         if (fill_level == 64) begin
            compress_block();
            fill_level = 0;
         end
      end
      if (!bt.last)
         return;
      bit_len = {length_bytes, 3'b000};
      block_buf[fill_level] = SMD_PAD_MARK;
      fill_level++;
      if (fill_level > 56) begin
         while (fill_level < 64) begin
            block_buf[fill_level] = 8'h00;
            fill_level++;
         end
         compress_block();
         fill_level = 0;
      end
      while (fill_level < 56) begin
         block_buf[fill_level] = 8'h00;
         fill_level++;
      end
      for (int i = 0; i < 8; i++)
         block_buf[56+i] = bit_len[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 5; i++) begin
         dw.digest_word = chain[i];
         dw.word_index  = 3'(i);
         dw.last_word   = (i == 4);
         digest_due.push_back(dw);
      end
      messages_hashed++;
      restart_chain();
   endfunction

   function automatic void push_beat(input logic [7:0] data, input logic valid_byte,
                                     input logic ends);
      byte_beat_type bt;
      bt.data_byte  = data;
      bt.byte_valid = valid_byte;
      bt.last       = ends;
      byte_queue.push_back(bt);
      beats_total++;
      if (valid_byte)
         bytes_queued++;
      if (ends)
         messages_queued++;
   endfunction

   // random content; the closing byte rides on the last beat about half the time
   function automatic void queue_message(input int unsigned len);
      bit tail_byte;
      tail_byte = (len > 0) && ($urandom_range(1) == 1);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0)
            push_beat(8'($urandom_range(255)), 1'b0, 1'b0);
         push_beat(8'($urandom_range(255)), 1'b1, tail_byte && (i == len - 1));
      end
      if (!tail_byte)
         push_beat(8'($urandom_range(255)), 1'b0, 1'b1);
   endfunction

   always @(posedge clock) begin : byte_driver
      byte_beat_type bt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            bt.data_byte  = req_bus.data_byte;
            bt.byte_valid = req_bus.byte_valid;
            bt.last       = req_bus.last;
            absorb_beat(bt);
            beats_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (byte_queue.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               bt = byte_queue.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.data_byte  <= bt.data_byte;
               req_bus.byte_valid <= bt.byte_valid;
               req_bus.last       <= bt.last;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         steady <= (beats_sent >= 120) && (beats_sent < 240);
      end
   end

   always @(posedge clock) begin : digest_monitor
      digest_beat_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            words_seen++;
            if (digest_due.size() == 0) begin
               report_mismatch($sformatf("digest beat %h with nothing expected",
                                         rsp_bus.digest_word));
            end else begin
               want = digest_due.pop_front();
               if (rsp_bus.digest_word !== want.digest_word)
                  report_mismatch($sformatf("digest_word %h, expected %h",
                                            rsp_bus.digest_word, want.digest_word));
               if (rsp_bus.word_index !== want.word_index)
                  report_mismatch($sformatf("word_index %0d, expected %0d",
                                            rsp_bus.word_index, want.word_index));
               if (rsp_bus.last_word !== want.last_word)
                  report_mismatch($sformatf("last_word %b, expected %b",
                                            rsp_bus.last_word, want.last_word));
            end
         end
         rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("no beat moved for %0d cycles", idle_cycles);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned boundary_lens [$];
      int unsigned len;
      int unsigned pick;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.data_byte  = 8'h00;
      req_bus.byte_valid = 1'b0;
      req_bus.last       = 1'b0;
      rsp_bus.ready      = 1'b0;
      steady             = 1'b0;
      mismatches         = 0;
      beats_total        = 0;
      beats_sent         = 0;
      words_seen         = 0;
      messages_queued    = 0;
      messages_hashed    = 0;
      bytes_queued       = 0;
      idle_cycles        = 0;
      restart_chain();

      push_beat(8'hff, 1'b0, 1'b0);   // no byte, not last: ignored
      push_beat(8'h00, 1'b0, 1'b1);   // empty message
      push_beat(8'h00, 1'b1, 1'b1);   // byte and last on one beat
      push_beat(8'hff, 1'b1, 1'b0);
      push_beat(8'h5a, 1'b0, 1'b0);
      push_beat(8'ha5, 1'b1, 1'b0);
      push_beat(8'h00, 1'b0, 1'b1);
      push_beat(8'h61, 1'b1, 1'b0);
      push_beat(8'h62, 1'b1, 1'b0);
      push_beat(8'h63, 1'b1, 1'b1);
      push_beat(8'h80, 1'b0, 1'b0);

      // padding fits, just fails to fit, and full-block boundaries
      boundary_lens = '{55, 56, 63, 64};
      pick = 0;
      while (beats_total < TARGET_BEATS || boundary_lens.size() > 0 || messages_queued < 16)
      begin
         if (pick % 3 == 0 && boundary_lens.size() > 0)
            len = boundary_lens.pop_front();
         else if ($urandom_range(9) == 0)
            len = $urandom_range(130);
         else
            len = $urandom_range(20);
         queue_message(len);
         pick++;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (beats_sent < beats_total)
         @(posedge clock);
      while (digest_due.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (digest_due.size() > 0)
         report_mismatch($sformatf("%0d digest words never arrived", digest_due.size()));
      $display("%0d beats carrying %0d bytes, %0d messages hashed", beats_sent, bytes_queued,
               messages_hashed);
      $display("%0d digest words checked, %0d mismatches", words_seen, mismatches);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
